// File: src/pps_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pps_pkg: shared types and constants for the priority scheduler
// Table size, field widths, register address and the structs that run
// along the cell chain and from the sequencer into the cells.
// ----------------------------------------------------------------------------
package pps_pkg;

  localparam int MAX_PROCS = 16;
  localparam int SLOT_W    = $clog2(MAX_PROCS);

  localparam int TIME_W  = 16;
  localparam int PRIO_W  = 8;
  localparam int CLOCK_W = 24;
  localparam int COUNT_W = 5;
  localparam int WAIT_W  = 25;
  localparam int SUM_W   = 32;

  localparam logic [CLOCK_W-1:0] CLOCK_MAX = {CLOCK_W{1'b1}};

  // configuration register map
  localparam int          ADDR_W             = 2;
  localparam logic [ADDR_W-1:0] ADDR_PROCESS_COUNT = 2'd0;

  // commands
  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_TICK = 1'b1;

  // best candidate so far plus a saturating count of slots with work
  typedef struct packed {
    logic              found;
    logic [PRIO_W-1:0] prio;
    logic [SLOT_W-1:0] idx;
    logic [TIME_W-1:0] arrival;
    logic [TIME_W-1:0] burst;
    logic              rem_one;
    logic [1:0]        work;
  } chain_t;

  // slot load broadcast
  typedef struct packed {
    logic              en;
    logic [SLOT_W-1:0] idx;
    logic [TIME_W-1:0] arrival;
    logic [TIME_W-1:0] burst;
    logic [PRIO_W-1:0] prio;
  } load_t;

  // one unit of work taken from a slot
  typedef struct packed {
    logic              en;
    logic [SLOT_W-1:0] idx;
  } dec_t;

endpackage

// File: src/pps_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pps_cell: one process slot of the scheduler chain
// Holds a slot's arrival, burst, priority and remaining work, and merges
// its own entry into the candidate handed on from the previous cell.
// ----------------------------------------------------------------------------
module pps_cell (
  input  logic                          clk,
  input  logic                          rst,
  input  logic [pps_pkg::SLOT_W-1:0]    index,
  input  logic                          active,
  input  logic [pps_pkg::CLOCK_W-1:0]   clock_ticks,
  input  pps_pkg::load_t                load,
  input  pps_pkg::dec_t                 dec,
  input  pps_pkg::chain_t               chain_in,
  output pps_pkg::chain_t               chain_out
);

  logic [pps_pkg::TIME_W-1:0] arrival;
  logic [pps_pkg::TIME_W-1:0] burst;
  logic [pps_pkg::PRIO_W-1:0] prio;
  logic [pps_pkg::TIME_W-1:0] remaining;

  logic            has_work;
  logic            eligible;
  logic            take;
  pps_pkg::chain_t chain_next;

  // slot entry: write on load, no reset
  always_ff @(posedge clk) begin
    if (load.en && load.idx == index) begin
      arrival <= load.arrival;
      burst   <= load.burst;
      prio    <= load.prio;
    end
  end

  // remaining work: cleared by reset, set on load, count down when picked
  always_ff @(posedge clk) begin
    if (rst) begin
      remaining <= '0;
    end else if (load.en && load.idx == index) begin
      remaining <= load.burst;
    end else if (dec.en && dec.idx == index) begin
      remaining <= remaining - 1'b1;
    end
  end

  // merge own entry into the passing candidate
  always_comb begin
    has_work = active && (remaining != '0);
    eligible = has_work &&
               ({{(pps_pkg::CLOCK_W-pps_pkg::TIME_W){1'b0}}, arrival} <= clock_ticks);
    take     = eligible && (!chain_in.found || prio < chain_in.prio);
    chain_next = chain_in;
    if (take) begin
      chain_next.found   = 1'b1;
      chain_next.prio    = prio;
      chain_next.idx     = index;
      chain_next.arrival = arrival;
      chain_next.burst   = burst;
      chain_next.rem_one = (remaining == pps_pkg::TIME_W'(1));
    end
    if (has_work && chain_in.work != 2'd2) begin
      chain_next.work = chain_in.work + 2'd1;
    end
  end

  // hand on to the next cell
  always_ff @(posedge clk) begin
    if (rst) begin
      chain_out <= '0;
    end else begin
      chain_out <= chain_next;
    end
  end

endmodule

// File: src/preemptive_priority_scheduler_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// preemptive_priority_scheduler_unit: priority scheduler over a slot table
// A load (command 0) is taken while idle and gives no result. A tick (command 1)
// runs the candidate through the chain of MAX_PROCS slot cells, one cell a
// cycle, then takes one unit of work and updates the totals: busy stays high
// through the scan, pick and totals steps, and the result appears with strobe
// high for one cycle as busy falls. The receiver cannot stall the result, so it
// must take every strobed transfer. The user must write process_count over the
// APB port only while busy is low; the block itself does not enforce this.
// ----------------------------------------------------------------------------
module preemptive_priority_scheduler_unit (
  input  logic                            clk,
  input  logic                            rst,
  // command channel
  input  logic                            start,
  output logic                            busy,
  input  logic                            command,
  input  logic [3:0]                      slot,
  input  logic [pps_pkg::TIME_W-1:0]      arrival_time,
  input  logic [pps_pkg::TIME_W-1:0]      burst_time,
  input  logic [pps_pkg::PRIO_W-1:0]      priority_req,
  // result channel
  output logic                            strobe,
  output logic [3:0]                      selected_slot,
  output logic                            idle,
  output logic                            finished,
  output logic [pps_pkg::CLOCK_W-1:0]     turnaround,
  output logic signed [pps_pkg::WAIT_W-1:0] waiting,
  output logic [pps_pkg::SUM_W-1:0]       total_turnaround,
  output logic [pps_pkg::SUM_W-1:0]       total_waiting,
  output logic                            all_done,
  // configuration
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [pps_pkg::ADDR_W-1:0]      paddr,
  input  logic [31:0]                     pwdata,
  output logic [31:0]                     prdata,
  output logic                            pready
);

  typedef enum logic [1:0] {ST_IDLE, ST_SCAN, ST_PICK, ST_DONE} state_t;

  state_t                          state;
  logic [pps_pkg::SLOT_W-1:0]      scan_cnt;
  logic [pps_pkg::COUNT_W-1:0]     process_count;
  logic [pps_pkg::CLOCK_W-1:0]     clock_ticks;
  logic [pps_pkg::SUM_W-1:0]       turnaround_sum;
  logic [pps_pkg::SUM_W-1:0]       waiting_sum;

  // tick held between pick and totals
  logic                            pick_found;
  logic [pps_pkg::SLOT_W-1:0]      pick_idx;
  logic                            pick_fin;
  logic [pps_pkg::CLOCK_W-1:0]     tat_q;
  logic signed [pps_pkg::WAIT_W-1:0] wt_q;
  logic                            all_done_q;

  pps_pkg::chain_t                 chain [0:pps_pkg::MAX_PROCS];
  pps_pkg::load_t                  load;
  pps_pkg::dec_t                   dec;

  logic                            accept;
  logic                            cfg_write;
  logic [pps_pkg::CLOCK_W-1:0]     clock_next;
  logic                            fin_now;
  logic [pps_pkg::CLOCK_W-1:0]     tat_now;
  logic signed [pps_pkg::WAIT_W-1:0] wt_now;
  logic                            all_done_now;
  logic [pps_pkg::SUM_W:0]         tat_sum_wide;
  logic signed [pps_pkg::SUM_W+1:0] wt_sum_wide;
  logic [pps_pkg::SUM_W-1:0]       tat_sum_next;
  logic [pps_pkg::SUM_W-1:0]       wt_sum_next;

  assign busy   = (state != ST_IDLE);
  assign accept = start && !busy;
  assign pready = 1'b1;

  // configuration port
  assign cfg_write = psel && penable && pwrite && pready;
  assign prdata    = (paddr == pps_pkg::ADDR_PROCESS_COUNT) ?
                     {{(32-pps_pkg::COUNT_W){1'b0}}, process_count} : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      process_count <= pps_pkg::COUNT_W'(1);
    end else if (cfg_write && paddr == pps_pkg::ADDR_PROCESS_COUNT) begin
      process_count <= pwdata[pps_pkg::COUNT_W-1:0];
    end
  end

  // load broadcast; slots beyond the table are dropped
  always_comb begin
    load.en      = accept && (command == pps_pkg::CMD_LOAD) &&
                   (32'(slot) < pps_pkg::MAX_PROCS);
    load.idx     = pps_pkg::SLOT_W'(slot);
    load.arrival = arrival_time;
    load.burst   = burst_time;
    load.prio    = priority_req;
  end

  // take one unit from the winner at the end of the chain
  always_comb begin
    dec.en  = (state == ST_PICK) && chain[pps_pkg::MAX_PROCS].found;
    dec.idx = chain[pps_pkg::MAX_PROCS].idx;
  end

  // cell chain
  assign chain[0] = '0;

  for (genvar g = 0; g < pps_pkg::MAX_PROCS; g++) begin : g_cell
    pps_cell u_cell (
      .clk         (clk),
      .rst         (rst),
      .index       (pps_pkg::SLOT_W'(g)),
      .active      (32'(g) < 32'(process_count)),
      .clock_ticks (clock_ticks),
      .load        (load),
      .dec         (dec),
      .chain_in    (chain[g]),
      .chain_out   (chain[g+1])
    );
  end

  // pick arithmetic: advance the clock, turnaround and waiting of the winner
  always_comb begin
    clock_next = (clock_ticks == pps_pkg::CLOCK_MAX) ? clock_ticks : clock_ticks + 1'b1;
    fin_now    = chain[pps_pkg::MAX_PROCS].found && chain[pps_pkg::MAX_PROCS].rem_one;
    tat_now    = clock_next -
                 {{(pps_pkg::CLOCK_W-pps_pkg::TIME_W){1'b0}},
                  chain[pps_pkg::MAX_PROCS].arrival};
    wt_now     = signed'({1'b0, tat_now}) -
                 signed'({{(pps_pkg::WAIT_W-pps_pkg::TIME_W){1'b0}},
                          chain[pps_pkg::MAX_PROCS].burst});
    all_done_now = (chain[pps_pkg::MAX_PROCS].work == 2'd0) ||
                   ((chain[pps_pkg::MAX_PROCS].work == 2'd1) && fin_now);
  end

  // totals: saturate turnaround sum, clamp waiting sum to its unsigned range
  always_comb begin
    tat_sum_wide = {1'b0, turnaround_sum} +
                   {{(pps_pkg::SUM_W+1-pps_pkg::CLOCK_W){1'b0}}, tat_q};
    tat_sum_next = tat_sum_wide[pps_pkg::SUM_W] ? {pps_pkg::SUM_W{1'b1}} :
                   tat_sum_wide[pps_pkg::SUM_W-1:0];
    wt_sum_wide  = signed'({2'b00, waiting_sum}) +
                   signed'({{(pps_pkg::SUM_W+2-pps_pkg::WAIT_W){wt_q[pps_pkg::WAIT_W-1]}},
                            wt_q});
    if (wt_sum_wide[pps_pkg::SUM_W+1]) begin
      wt_sum_next = '0;
    end else if (wt_sum_wide[pps_pkg::SUM_W]) begin
      wt_sum_next = {pps_pkg::SUM_W{1'b1}};
    end else begin
      wt_sum_next = wt_sum_wide[pps_pkg::SUM_W-1:0];
    end
  end

  // sequencer, scheduler state and registered results
  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= ST_IDLE;
      scan_cnt       <= '0;
      clock_ticks    <= '0;
      turnaround_sum <= '0;
      waiting_sum    <= '0;
      strobe         <= 1'b0;
    end else begin
      strobe <= 1'b0;
      case (state)
        ST_IDLE: begin
          if (load.en) begin
            clock_ticks    <= '0;
            turnaround_sum <= '0;
            waiting_sum    <= '0;
          end else if (accept && command == pps_pkg::CMD_TICK) begin
            scan_cnt <= '0;
            state    <= ST_SCAN;
          end
        end
        ST_SCAN: begin
          scan_cnt <= scan_cnt + 1'b1;
          if (scan_cnt == pps_pkg::SLOT_W'(pps_pkg::MAX_PROCS - 1)) begin
            state <= ST_PICK;
          end
        end
        ST_PICK: begin
          clock_ticks <= clock_next;
          pick_found  <= chain[pps_pkg::MAX_PROCS].found;
          pick_idx    <= chain[pps_pkg::MAX_PROCS].idx;
          pick_fin    <= fin_now;
          tat_q       <= fin_now ? tat_now : '0;
          wt_q        <= fin_now ? wt_now : '0;
          all_done_q  <= all_done_now;
          state       <= ST_DONE;
        end
        ST_DONE: begin
          if (pick_fin) begin
            turnaround_sum   <= tat_sum_next;
            waiting_sum      <= wt_sum_next;
            total_turnaround <= tat_sum_next;
            total_waiting    <= wt_sum_next;
          end else begin
            total_turnaround <= turnaround_sum;
            total_waiting    <= waiting_sum;
          end
          selected_slot <= pick_found ? 4'(pick_idx) : 4'd0;
          idle          <= !pick_found;
          finished      <= pick_fin;
          turnaround    <= tat_q;
          waiting       <= wt_q;
          all_done      <= all_done_q;
          strobe        <= 1'b1;
          state         <= ST_IDLE;
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // a result only ever follows the totals step
  assert property (@(posedge clk) disable iff (rst)
    strobe |-> $past(state) == ST_DONE)
    else $error("result strobe without a completed tick");

  // an idle tick never reports a completion
  assert property (@(posedge clk) disable iff (rst)
    strobe && idle |-> !finished && turnaround == '0 && waiting == '0)
    else $error("idle tick reports a completion");

  // work is taken from a slot at most once per tick
  assert property (@(posedge clk) disable iff (rst)
    state == ST_PICK |=> state == ST_DONE && !dec.en)
    else $error("pick step repeated");

  // the clock only moves back on a load
  assert property (@(posedge clk) disable iff (rst)
    !load.en |=> clock_ticks >= $past(clock_ticks))
    else $error("clock went backwards without a load");

  // a tick transfer starts the chain scan
  assert property (@(posedge clk) disable iff (rst)
    accept && command == pps_pkg::CMD_TICK |=> state == ST_SCAN && scan_cnt == '0)
    else $error("tick did not start a scan");

endmodule

// File: tb/preemptive_priority_scheduler_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// preemptive_priority_scheduler_unit_tb: self-checking bench for the scheduler
// Drives load and tick commands through the start/busy handshake with random
// gaps, predicts every tick result from a local copy of the slot table, clock
// and totals, and compares each strobed result field by field. process_count
// is written and read back over APB between phases, once the block is idle.
// ----------------------------------------------------------------------------
module preemptive_priority_scheduler_unit_tb;

  localparam longint SUM_TOP     = 64'h0000_0000_FFFF_FFFF;
  localparam int     ITEM_TARGET = 720;
  localparam int     DRAIN_WAIT  = 2 * pps_pkg::MAX_PROCS + 8;

  typedef struct {
    logic                       cmd;
    logic [3:0]                 slot;
    logic [pps_pkg::TIME_W-1:0] arrival;
    logic [pps_pkg::TIME_W-1:0] burst;
    logic [pps_pkg::PRIO_W-1:0] prio;
  } sched_cmd_t;

  typedef struct {
    logic [3:0]                  slot;
    logic                        idle;
    logic                        finished;
    logic [pps_pkg::CLOCK_W-1:0] tat;
    logic [pps_pkg::WAIT_W-1:0]  wait_val;
    logic [pps_pkg::SUM_W-1:0]   tat_sum;
    logic [pps_pkg::SUM_W-1:0]   wait_sum;
    logic                        all_done;
  } sched_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                         start        = 1'b0;
  logic                         command      = 1'b0;
  logic [3:0]                   slot         = '0;
  logic [pps_pkg::TIME_W-1:0]   arrival_time = '0;
  logic [pps_pkg::TIME_W-1:0]   burst_time   = '0;
  logic [pps_pkg::PRIO_W-1:0]   priority_req = '0;
  logic                         psel         = 1'b0;
  logic                         penable      = 1'b0;
  logic                         pwrite       = 1'b0;
  logic [pps_pkg::ADDR_W-1:0]   paddr        = '0;
  logic [31:0]                  pwdata       = '0;

  logic                              busy;
  logic                              strobe;
  logic [3:0]                        selected_slot;
  logic                              idle;
  logic                              finished;
  logic [pps_pkg::CLOCK_W-1:0]       turnaround;
  logic signed [pps_pkg::WAIT_W-1:0] waiting;
  logic [pps_pkg::SUM_W-1:0]         total_turnaround;
  logic [pps_pkg::SUM_W-1:0]         total_waiting;
  logic                              all_done;
  logic [31:0]                       prdata;
  logic                              pready;

  // scheduler state as the block should hold it
  logic [pps_pkg::TIME_W-1:0]  proc_arrival [pps_pkg::MAX_PROCS];
  logic [pps_pkg::TIME_W-1:0]  proc_burst   [pps_pkg::MAX_PROCS];
  logic [pps_pkg::TIME_W-1:0]  proc_left    [pps_pkg::MAX_PROCS];
  logic [pps_pkg::PRIO_W-1:0]  proc_prio    [pps_pkg::MAX_PROCS];
  logic [pps_pkg::CLOCK_W-1:0] sched_clock;
  logic [pps_pkg::SUM_W-1:0]   tat_total;
  logic [pps_pkg::SUM_W-1:0]   wait_total;
  logic [4:0]                  proc_count;

  sched_cmd_t    pending_cmds[$];
  sched_result_t expected_results[$];
  sched_cmd_t    cur_cmd;
  int            mismatches = 0;
  int            item_total = 0;
  int            quiet_left = 0;

  preemptive_priority_scheduler_unit uut (
    .clk              (clk),
    .rst              (rst),
    .start            (start),
    .busy             (busy),
    .command          (command),
    .slot             (slot),
    .arrival_time     (arrival_time),
    .burst_time       (burst_time),
    .priority_req     (priority_req),
    .strobe           (strobe),
    .selected_slot    (selected_slot),
    .idle             (idle),
    .finished         (finished),
    .turnaround       (turnaround),
    .waiting          (waiting),
    .total_turnaround (total_turnaround),
    .total_waiting    (total_waiting),
    .all_done         (all_done),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata),
    .pready           (pready)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Count a failed comparison; report only the first few in full.
  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (got !== want) begin
      mismatches++;
      if (mismatches <= 10)
        $display("%0t: %s mismatch, expected %0h, got %0h", $realtime, name, want, got);
    end
  endtask

  // Apply one accepted command to the local state; ticks queue a result.
  task automatic schedule_step(input sched_cmd_t c);
    int unsigned                 n;
    logic                        found;
    logic                        fin;
    logic                        done_flag;
    logic [3:0]                  pick;
    logic [pps_pkg::PRIO_W-1:0]  best;
    logic [pps_pkg::CLOCK_W-1:0] tat;
    longint                      wt;
    longint                      sum;
    sched_result_t               r;
    if (c.cmd == pps_pkg::CMD_LOAD) begin
      proc_arrival[c.slot] = c.arrival;
      proc_burst[c.slot]   = c.burst;
      proc_left[c.slot]    = c.burst;
      proc_prio[c.slot]    = c.prio;
      sched_clock          = '0;
      tat_total            = '0;
      wait_total           = '0;
      return;
    end
    n     = (proc_count > pps_pkg::MAX_PROCS) ? pps_pkg::MAX_PROCS : proc_count;
    found = 1'b0;
    fin   = 1'b0;
    pick  = '0;
    best  = '0;
    tat   = '0;
    wt    = 0;
    // lowest priority value among arrived slots with work, lower index on a tie
    for (int i = 0; i < n; i++) begin
      if (proc_left[i] != 0 && proc_arrival[i] <= sched_clock &&
          (!found || proc_prio[i] < best)) begin
        found = 1'b1;
        best  = proc_prio[i];
        pick  = i[3:0];
      end
    end
    if (sched_clock != pps_pkg::CLOCK_MAX)
      sched_clock++;
    if (found) begin
      proc_left[pick]--;
      if (proc_left[pick] == 0) begin
        fin = 1'b1;
        tat = sched_clock - proc_arrival[pick];
        wt  = longint'(tat) - longint'(proc_burst[pick]);
        sum = longint'(tat_total) + longint'(tat);
        tat_total = (sum > SUM_TOP) ? '1 : sum[31:0];
        // waiting total is clamped at both ends
        sum = longint'(wait_total) + wt;
        if (sum < 0)
          sum = 0;
        else if (sum > SUM_TOP)
          sum = SUM_TOP;
        wait_total = sum[31:0];
      end
    end
    done_flag = 1'b1;
    for (int i = 0; i < n; i++)
      if (proc_left[i] != 0)
        done_flag = 1'b0;
    r.slot     = found ? pick : 4'd0;
    r.idle     = !found;
    r.finished = fin;
    r.tat      = tat;
    r.wait_val = wt[pps_pkg::WAIT_W-1:0];
    r.tat_sum  = tat_total;
    r.wait_sum = wait_total;
    r.all_done = done_flag;
    expected_results.push_back(r);
  endtask

  // Driver: present queued commands, hold while busy, random gaps between.
  always @(posedge clk) begin : drive_cmds
    int gap;
    if (rst) begin
      start <= 1'b0;
      gap = 0;
    end else if (!(start && busy)) begin
      if (start) begin
        // transfer taken at this edge
        schedule_step(cur_cmd);
        gap = 0;
        if (quiet_left > 0) begin
          quiet_left--;
        end else begin
          gap = $urandom_range(0, 6);
          if ($urandom_range(0, 24) == 0)
            quiet_left = $urandom_range(8, 32);
        end
      end
      if (gap > 0 && !start && !busy)
        gap--;
      if (gap == 0 && pending_cmds.size() != 0) begin
        cur_cmd      = pending_cmds.pop_front();
        command      <= cur_cmd.cmd;
        slot         <= cur_cmd.slot;
        arrival_time <= cur_cmd.arrival;
        burst_time   <= cur_cmd.burst;
        priority_req <= cur_cmd.prio;
        start        <= 1'b1;
      end else begin
        start <= 1'b0;
      end
    end
  end

  // Monitor: every strobed result must match the oldest expectation.
  always @(posedge clk) begin : check_results
    sched_result_t want;
    if (!rst && strobe) begin
      if (expected_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: result with none expected, slot %0h idle %0b", $realtime,
                   selected_slot, idle);
      end else begin
        want = expected_results.pop_front();
        check_field("selected_slot", want.slot, selected_slot);
        check_field("idle", want.idle, idle);
        check_field("finished", want.finished, finished);
        check_field("turnaround", want.tat, turnaround);
        check_field("waiting", want.wait_val, $unsigned(waiting));
        check_field("total_turnaround", want.tat_sum, total_turnaround);
        check_field("total_waiting", want.wait_sum, total_waiting);
        check_field("all_done", want.all_done, all_done);
      end
    end
  end

  task automatic add_load(input logic [3:0] s, input logic [pps_pkg::TIME_W-1:0] arr,
                          input logic [pps_pkg::TIME_W-1:0] bt,
                          input logic [pps_pkg::PRIO_W-1:0] pr);
    sched_cmd_t c;
    c.cmd     = pps_pkg::CMD_LOAD;
    c.slot    = s;
    c.arrival = arr;
    c.burst   = bt;
    c.prio    = pr;
    pending_cmds.push_back(c);
    item_total++;
  endtask

  // Tick with junk on the unused fields
  task automatic add_tick();
    sched_cmd_t c;
    c.cmd     = pps_pkg::CMD_TICK;
    c.slot    = 4'($urandom_range(0, 15));
    c.arrival = 16'($urandom_range(0, 65535));
    c.burst   = 16'($urandom_range(0, 65535));
    c.prio    = 8'($urandom_range(0, 255));
    pending_cmds.push_back(c);
    item_total++;
  endtask

  // Wait until every command is taken and every result is in, then drain.
  task automatic settle();
    int spin;
    while (pending_cmds.size() != 0 || start)
      @(posedge clk);
    spin = 0;
    while ((busy || expected_results.size() != 0) && spin < 1000) begin
      @(posedge clk);
      spin++;
    end
    repeat (DRAIN_WAIT) @(posedge clk);
  endtask

  // APB write of process_count followed by a read-back
  task automatic write_count(input logic [31:0] value);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= pps_pkg::ADDR_PROCESS_COUNT;
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    proc_count = value[4:0];
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    check_field("process_count read", {27'd0, value[4:0]}, prdata);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  initial begin : stimulus
    int pc;
    int n;
    int nl;
    int s;
    int j;
    int tmp;
    int work;
    int latest;
    int ticks;
    int order [pps_pkg::MAX_PROCS];
    logic [pps_pkg::TIME_W-1:0] arr;
    logic [pps_pkg::TIME_W-1:0] bt;
    logic [pps_pkg::PRIO_W-1:0] pr;

    for (int i = 0; i < pps_pkg::MAX_PROCS; i++) begin
      proc_arrival[i] = '0;
      proc_burst[i]   = '0;
      proc_left[i]    = '0;
      proc_prio[i]    = '0;
    end
    sched_clock = '0;
    tat_total   = '0;
    wait_total  = '0;
    proc_count  = 5'd1;

    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset count of one: idle tick on an empty table, a short run, zero burst
    add_tick();
    add_load(4'd0, 16'd0, 16'd2, 8'hFF);
    add_tick();
    add_tick();
    add_load(4'd0, 16'd0, 16'd0, 8'h00);
    add_tick();
    settle();

    // full table: tie on priority, field extremes, and a load that clears the
    // clock mid-run so the next completion shows a negative waiting time
    write_count({27'($urandom_range(0, 32'h07FF_FFFF)), 5'd16});
    add_load(4'd3, 16'd0, 16'd2, 8'h00);
    add_load(4'd15, 16'd0, 16'd1, 8'h00);
    add_tick();
    add_load(4'd9, 16'hFFFF, 16'hFFFF, 8'hFF);
    add_tick();
    add_tick();
    add_tick();
    add_load(4'd9, 16'd0, 16'd0, 8'h00);
    add_tick();
    settle();

    // count of zero: nothing takes part
    write_count(32'd0);
    add_load(4'd0, 16'd0, 16'd3, 8'd5);
    add_tick();
    add_tick();
    settle();

    // count above the table size behaves as a full table
    write_count(32'hFFFF_FFFF);
    add_tick();
    settle();

    // random phases of well-formed workloads with some noise
    while (item_total < ITEM_TARGET) begin
      case ($urandom_range(0, 11))
        0:       pc = 0;
        1:       pc = 16;
        2:       pc = $urandom_range(17, 31);
        3:       pc = 1;
        default: pc = $urandom_range(2, 8);
      endcase
      write_count({27'($urandom_range(0, 32'h07FF_FFFF)), pc[4:0]});
      n  = (pc > pps_pkg::MAX_PROCS) ? pps_pkg::MAX_PROCS : pc;
      nl = (n == 0) ? 3 : n;
      repeat ($urandom_range(1, 3)) begin
        for (int k = 0; k < nl; k++)
          order[k] = k;
        for (int k = nl - 1; k > 0; k--) begin
          j        = $urandom_range(0, k);
          tmp      = order[k];
          order[k] = order[j];
          order[j] = tmp;
        end
        // load every taking-part slot in shuffled order
        work   = 0;
        latest = 0;
        for (int k = 0; k < nl; k++) begin
          s  = (n == 0) ? $urandom_range(0, 15) : order[k];
          bt = ($urandom_range(0, 4) == 0) ? 16'd0 : 16'($urandom_range(1, 6));
          if ($urandom_range(0, 15) == 0) begin
            arr = 16'($urandom_range(16'hFF00, 16'hFFFF));
          end else begin
            arr  = 16'($urandom_range(0, 12));
            work = work + bt;
            if (arr > latest)
              latest = arr;
          end
          pr = $urandom_range(0, 1) ? 8'($urandom_range(0, 3)) : 8'($urandom_range(0, 255));
          add_load(s[3:0], arr, bt, pr);
        end
        if ($urandom_range(0, 9) == 0)
          add_load(4'($urandom_range(0, 15)), 16'($urandom_range(0, 65535)),
                   16'($urandom_range(0, 65535)), 8'($urandom_range(0, 255)));
        // run the workload out, sometimes reloading a slot part way
        ticks = work + latest + $urandom_range(0, 4);
        for (int t = 0; t < ticks; t++) begin
          if ($urandom_range(0, 24) == 0)
            add_load(4'($urandom_range(0, nl - 1)), 16'($urandom_range(0, 4)),
                     16'($urandom_range(0, 4)), 8'($urandom_range(0, 255)));
          add_tick();
        end
      end
      settle();
    end

    settle();
    if (expected_results.size() != 0)
      $display("%0d expected results never arrived", expected_results.size());
    if (mismatches == 0 && expected_results.size() == 0)
      $display("SUCCESS");
    else
      $display("FAILURE");
    $finish;
  end

  // hard limit on the run
  initial begin
    #3_000_000;
    $display("FAILURE");
    $finish;
  end

endmodule
